@@ sv/tsa_pkg.sv @@
// Shared constants, codes and request types for the task slot allocator.
package tsa_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int SLOT_W      = 5;
    localparam int IDX_W       = $clog2(SLOT_COUNT);
    localparam int STACK_DEPTH = SLOT_COUNT - 1;
    localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        SS_NEVER = 2'd0,
        SS_ALLOC = 2'd1,
        SS_FREE  = 2'd2
    } t_slot_state;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_EXHAUSTED = 2'd1,
        RES_INVALID   = 2'd2,
        RES_NOT_ALLOC = 2'd3
    } t_result;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] slot;
    } t_stack_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot_state      state;
    } t_tbl_wr;

endpackage

@@ sv/tsa_slot_table.sv @@
// Slot state memory with per-entry valid bits that restore the reset state.
module tsa_slot_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [tsa_pkg::IDX_W-1:0] i_rd_addr,
    input  tsa_pkg::t_tbl_wr          i_wr,
    output tsa_pkg::t_slot_state      o_rd_state
);
    import tsa_pkg::*;

    t_slot_state           mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    t_slot_state           r_rd_state;
    t_slot_state           n_rd_state;

    always_comb begin
        if (r_valid[i_rd_addr]) begin
            n_rd_state = mem[i_rd_addr];
        end else if (i_rd_addr == '0) begin
            n_rd_state = SS_ALLOC;
        end else begin
            n_rd_state = SS_NEVER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.state;
        end
        if (i_rd_en) begin
            r_rd_state <= n_rd_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_state = r_rd_state;

endmodule

@@ sv/tsa_free_stack.sv @@
// LIFO memory of released slots with its depth pointer.
module tsa_free_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  tsa_pkg::t_stack_req        i_req,
    output logic [tsa_pkg::SLOT_W-1:0] o_rd_slot,
    output logic [tsa_pkg::SLOT_W-1:0] o_depth
);
    import tsa_pkg::*;

    logic [SLOT_W-1:0] mem [STACK_DEPTH];
    logic [SLOT_W-1:0] r_depth;
    logic [SLOT_W-1:0] n_depth;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [SLOT_W-1:0] top_idx;
    logic              can_push;

    assign top_idx  = r_depth - 1'b1;
    assign can_push = (r_depth < SLOT_W'(STACK_DEPTH));

    always_comb begin
        n_depth = r_depth;
        if (i_req.pop && r_depth != '0) begin
            n_depth = r_depth - 1'b1;
        end else if (i_req.push && can_push) begin
            n_depth = r_depth + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push && !i_req.pop && can_push) begin
            mem[r_depth[STK_IDX_W-1:0]] <= i_req.slot;
        end
        if (i_rd_en) begin
            r_rd_slot <= mem[top_idx[STK_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    assign o_rd_slot = r_rd_slot;
    assign o_depth   = r_depth;

endmodule

@@ sv/task_slot_allocator_top.sv @@
// Top level: request control, fresh-slot pointer, counts and result registers.
// A taken start enters the execute state; the result registers and strobe are loaded as it ends.
// Busy is high in the execute state; a new request is taken only once the last one is done.
// Each request reads the slot table and the stack together, then updates them as needed.
// Synchronous active-low reset: slot 0 allocated, all others never used, stack empty.
// The receiver cannot stall; each result is shown for exactly one cycle.
module task_slot_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [4:0]                 i_release_slot,
    output logic                       o_result_valid,
    output logic [1:0]                 o_status,
    output logic [4:0]                 o_granted_slot,
    output logic [4:0]                 o_slots_in_use,
    output logic [4:0]                 o_slots_available
);
    import tsa_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state            r_state;
    logic              r_busy;
    t_opcode           r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_fresh;
    logic [SLOT_W-1:0] n_fresh;
    logic [SLOT_W-1:0] r_in_use;
    logic [SLOT_W-1:0] n_in_use;
    logic              r_valid;
    t_result           r_status;
    t_result           n_status;
    logic [SLOT_W-1:0] r_grant;
    logic [SLOT_W-1:0] n_grant;
    logic [SLOT_W-1:0] r_avail;
    logic [SLOT_W-1:0] r_used;

    logic              accept;
    logic              exec;
    t_slot_state       tbl_rd;
    t_tbl_wr           tbl_wr;
    t_stack_req        stk_req;
    logic [SLOT_W-1:0] stk_rd;
    logic [SLOT_W-1:0] stk_depth;

    assign accept = start && !r_busy;
    assign exec   = (r_state == ST_EXEC);

    tsa_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (i_release_slot[IDX_W-1:0]),
        .i_wr       (tbl_wr),
        .o_rd_state (tbl_rd)
    );

    tsa_free_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_req     (stk_req),
        .o_rd_slot (stk_rd),
        .o_depth   (stk_depth)
    );

    always_comb begin
        n_status = RES_OK;
        n_grant  = '0;
        n_in_use = r_in_use;
        n_fresh  = r_fresh;
        stk_req  = '0;
        tbl_wr   = '0;
        if (exec) begin
            unique case (r_op)
                OP_ALLOC: begin
                    if (stk_depth != '0) begin
                        stk_req.pop  = 1'b1;
                        n_grant      = stk_rd;
                    end else if (r_fresh < SLOT_W'(SLOT_COUNT)) begin
                        n_grant      = r_fresh;
                        n_fresh      = r_fresh + 1'b1;
                    end else begin
                        n_status     = RES_EXHAUSTED;
                    end
                    if (n_status == RES_OK) begin
                        tbl_wr.en    = 1'b1;
                        tbl_wr.addr  = n_grant[IDX_W-1:0];
                        tbl_wr.state = SS_ALLOC;
                        n_in_use     = r_in_use + 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (r_slot == '0 || r_slot >= SLOT_W'(SLOT_COUNT)) begin
                        n_status = RES_INVALID;
                    end else if (tbl_rd != SS_ALLOC) begin
                        n_status = RES_NOT_ALLOC;
                    end else begin
                        tbl_wr.en    = 1'b1;
                        tbl_wr.addr  = r_slot[IDX_W-1:0];
                        tbl_wr.state = SS_FREE;
                        stk_req.push = 1'b1;
                        stk_req.slot = r_slot;
                        if (r_in_use != '0) begin
                            n_in_use = r_in_use - 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = RES_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_fresh  <= SLOT_W'(1);
            r_in_use <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    r_state  <= ST_IDLE;
                    r_busy   <= 1'b0;
                    r_valid  <= 1'b1;
                    r_fresh  <= n_fresh;
                    r_in_use <= n_in_use;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_opcode'(i_opcode);
            r_slot <= i_release_slot;
        end
        if (exec) begin
            r_status <= n_status;
            r_grant  <= n_grant;
            r_used   <= n_in_use;
            r_avail  <= SLOT_W'(SLOT_COUNT - 1) - n_in_use;
        end
    end

    assign busy              = r_busy;
    assign o_result_valid    = r_valid;
    assign o_status          = r_status;
    assign o_granted_slot    = r_grant;
    assign o_slots_in_use    = r_used;
    assign o_slots_available = r_avail;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the task slot allocator: directed table, random requests, scoreboard.
module tb;
    import tsa_pkg::*;

    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 1950;
    localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;
    localparam int CALM_LO    = N_DIRECTED + 600;
    localparam int CALM_HI    = N_DIRECTED + 900;
    localparam int PHASE_LEN  = 120;
    localparam int LIMIT      = 200000;

    typedef struct packed {
        t_result           status;
        logic [SLOT_W-1:0] granted;
        logic [SLOT_W-1:0] in_use;
        logic [SLOT_W-1:0] avail;
    } t_slot_result;

    typedef struct packed {
        t_opcode           op;
        logic [SLOT_W-1:0] slot;
        logic              fixed;
        t_slot_result      want;
    } t_slot_request;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              i_opcode       = 1'b0;
    logic [4:0]        i_release_slot = '0;
    logic              busy;
    logic              o_result_valid;
    logic [1:0]        o_status;
    logic [4:0]        o_granted_slot;
    logic [4:0]        o_slots_in_use;
    logic [4:0]        o_slots_available;

    t_slot_state       slot_st [SLOT_COUNT];
    logic [SLOT_W-1:0] free_stk [STACK_DEPTH];
    int                stk_cnt;
    int                fresh_ptr;
    int                used_cnt;

    t_slot_request     dir_tbl [N_DIRECTED];
    t_slot_request     cur;
    t_slot_result      pending_results [$];
    int                item_idx  = 0;
    int                gap_left  = 0;
    int                err_cnt   = 0;
    logic              stim_done = 1'b0;

    task_slot_allocator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_release_slot    (i_release_slot),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_slots_in_use    (o_slots_in_use),
        .o_slots_available (o_slots_available)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_slot_request make_row(t_opcode op, int slot, logic fixed,
                                               t_result st, int granted, int in_use);
        t_slot_request r;
        r.op           = op;
        r.slot         = SLOT_W'(slot);
        r.fixed        = fixed;
        r.want.status  = st;
        r.want.granted = SLOT_W'(granted);
        r.want.in_use  = SLOT_W'(in_use);
        r.want.avail   = SLOT_W'(SLOT_COUNT - 1 - in_use);
        return r;
    endfunction

    function automatic t_slot_result apply_request(t_opcode op, logic [SLOT_W-1:0] slot);
        t_slot_result r;
        int           pick;
        r.status  = RES_OK;
        r.granted = '0;
        if (op == OP_ALLOC) begin
            pick = -1;
            if (stk_cnt > 0) begin
                stk_cnt--;
                pick = free_stk[stk_cnt];
            end else if (fresh_ptr < SLOT_COUNT) begin
                pick = fresh_ptr;
                fresh_ptr++;
            end
            if (pick >= 0) begin
                slot_st[pick] = SS_ALLOC;
                used_cnt++;
                r.granted = SLOT_W'(pick);
            end else begin
                r.status = RES_EXHAUSTED;
            end
        end else if (slot == 0 || slot >= SLOT_COUNT) begin
            r.status = RES_INVALID;
        end else if (slot_st[slot] != SS_ALLOC) begin
            r.status = RES_NOT_ALLOC;
        end else begin
            slot_st[slot] = SS_FREE;
            if (stk_cnt < STACK_DEPTH) begin
                free_stk[stk_cnt] = slot;
                stk_cnt++;
            end
            if (used_cnt > 0) used_cnt--;
        end
        r.in_use = SLOT_W'(used_cnt);
        r.avail  = SLOT_W'(SLOT_COUNT - 1 - used_cnt);
        return r;
    endfunction

    function automatic t_slot_request random_request(int idx);
        t_slot_request r;
        int            owned [$];
        int            idle_or_free [$];
        int            roll;
        int            alloc_pct;
        r = '0;
        alloc_pct = (((idx - N_DIRECTED) / PHASE_LEN) % 2 == 0) ? 75 : 25;
        if ($urandom_range(99) < alloc_pct) begin
            r.op   = OP_ALLOC;
            r.slot = SLOT_W'($urandom_range(31));
            return r;
        end
        r.op = OP_RELEASE;
        for (int s = 1; s < SLOT_COUNT; s++) begin
            if (slot_st[s] == SS_ALLOC) owned.push_back(s);
            else idle_or_free.push_back(s);
        end
        roll = $urandom_range(99);
        if (roll < 70 && owned.size() > 0)
            r.slot = SLOT_W'(owned[$urandom_range(owned.size() - 1)]);
        else if (roll < 85 || idle_or_free.size() == 0)
            r.slot = SLOT_W'($urandom_range(31));
        else
            r.slot = SLOT_W'(idle_or_free[$urandom_range(idle_or_free.size() - 1)]);
        return r;
    endfunction

    task automatic load_next();
        if (item_idx < N_DIRECTED) cur = dir_tbl[item_idx];
        else cur = random_request(item_idx);
        start          <= 1'b1;
        i_opcode       <= cur.op;
        i_release_slot <= cur.slot;
    endtask

    task automatic drive_noise();
        i_opcode       <= t_opcode'($urandom_range(1));
        i_release_slot <= 5'($urandom_range(31));
    endtask

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                             $time, o_status, o_granted_slot);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("granted_slot", want.granted, o_granted_slot);
                    check_field("slots_in_use", want.in_use, o_slots_in_use);
                    check_field("slots_available", want.avail, o_slots_available);
                end
            end
            if (start && !busy) begin
                want = apply_request(cur.op, cur.slot);
                pending_results.push_back(cur.fixed ? cur.want : want);
                item_idx++;
                if (item_idx == N_ITEMS) begin
                    start     <= 1'b0;
                    stim_done <= 1'b1;
                end else if ((item_idx < CALM_LO || item_idx >= CALM_HI)
                             && $urandom_range(99) < 36) begin
                    start    <= 1'b0;
                    gap_left <= $urandom_range(3);
                    drive_noise();
                end else begin
                    load_next();
                end
            end else if (!start && !stim_done) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    drive_noise();
                end else begin
                    load_next();
                end
            end
        end
    end

    initial begin
        foreach (slot_st[s]) slot_st[s] = SS_NEVER;
        slot_st[0] = SS_ALLOC;
        foreach (free_stk[s]) free_stk[s] = '0;
        stk_cnt   = 0;
        fresh_ptr = 1;
        used_cnt  = 0;

        dir_tbl[0] = make_row(OP_RELEASE, 0, 1'b1, RES_INVALID, 0, 0);
        dir_tbl[1] = make_row(OP_RELEASE, 31, 1'b1, RES_INVALID, 0, 0);
        dir_tbl[2] = make_row(OP_RELEASE, SLOT_COUNT, 1'b1, RES_INVALID, 0, 0);
        dir_tbl[3] = make_row(OP_RELEASE, 5, 1'b1, RES_NOT_ALLOC, 0, 0);
        dir_tbl[4] = make_row(OP_ALLOC, 31, 1'b1, RES_OK, 1, 1);
        dir_tbl[5] = make_row(OP_ALLOC, 0, 1'b1, RES_OK, 2, 2);
        dir_tbl[6] = make_row(OP_RELEASE, 1, 1'b1, RES_OK, 0, 1);
        dir_tbl[7] = make_row(OP_RELEASE, 1, 1'b1, RES_NOT_ALLOC, 0, 1);
        dir_tbl[8] = make_row(OP_ALLOC, 0, 1'b1, RES_OK, 1, 2);
        for (int k = 9; k < 22; k++)
            dir_tbl[k] = make_row(OP_ALLOC, k, 1'b0, RES_OK, 0, 0);
        dir_tbl[22] = make_row(OP_ALLOC, 0, 1'b1, RES_EXHAUSTED, 0, SLOT_COUNT - 1);
        dir_tbl[23] = make_row(OP_RELEASE, SLOT_COUNT - 1, 1'b0, RES_OK, 0, 0);
        dir_tbl[24] = make_row(OP_ALLOC, 0, 1'b0, RES_OK, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tsa_pkg.sv
sv/tsa_slot_table.sv
sv/tsa_free_stack.sv
sv/task_slot_allocator_top.sv
tb/tb.sv
